// ----- hdl/cwd_pkg.sv -----
// ----------------------------------------------------------------------------
// cwd_pkg
// shared types, tables and the word descramble function
// ----------------------------------------------------------------------------
`default_nettype none

package cwd_pkg;

    localparam int OFF_W  = 23;
    localparam int WORD_W = 16;
    localparam int PC_W   = 24;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_A = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_B = 1'd1;

    localparam logic [1:0] KEY_T0 = 2'd0;
    localparam logic [1:0] KEY_T1 = 2'd1;
    localparam logic [1:0] KEY_T2 = 2'd2;

    localparam logic [5:0] TYPE0_KEY = 6'h3a;

    typedef logic [3:0] t_perm [16];

    localparam t_perm PERM_SEL [4] = '{
        '{4'd1,  4'd2,  4'd0,  4'd14, 4'd12, 4'd15, 4'd4,  4'd8,
          4'd13, 4'd7,  4'd3,  4'd6,  4'd11, 4'd5,  4'd10, 4'd9},
        '{4'd14, 4'd10, 4'd4,  4'd15, 4'd1,  4'd6,  4'd12, 4'd11,
          4'd8,  4'd0,  4'd9,  4'd13, 4'd7,  4'd3,  4'd5,  4'd2},
        '{4'd2,  4'd13, 4'd15, 4'd1,  4'd12, 4'd8,  4'd14, 4'd4,
          4'd6,  4'd0,  4'd9,  4'd5,  4'd10, 4'd7,  4'd3,  4'd11},
        '{4'd3,  4'd8,  4'd1,  4'd13, 4'd14, 4'd4,  4'd15, 4'd0,
          4'd10, 4'd2,  4'd7,  4'd12, 4'd6,  4'd11, 4'd9,  4'd5}
    };

    localparam t_perm PERM_FINAL = '{
        4'd2, 4'd6, 4'd0, 4'd11, 4'd14, 4'd12, 4'd7, 4'd10,
        4'd5, 4'd4, 4'd8, 4'd3,  4'd9,  4'd1,  4'd13, 4'd15};

    typedef struct packed {
        logic              chain;
        logic [WORD_W-1:0] prev_cipher;
        logic [WORD_W-1:0] prev_plain;
    } t_pair_ctx;

    // entry i gives the source bit of result bit 15-i
    function automatic logic [WORD_W-1:0] permute(input logic [WORD_W-1:0] v,
                                                  input t_perm tab);
        logic [WORD_W-1:0] r;
        r = '0;
        for (int i = 0; i < WORD_W; i++) begin
            r[WORD_W-1-i] = v[tab[i]];
        end
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] descramble(input logic [WORD_W-1:0] ka,
                                                     input logic [WORD_W-1:0] kb,
                                                     input logic [WORD_W-1:0] pe,
                                                     input logic [WORD_W-1:0] pd,
                                                     input logic [WORD_W-1:0] w);
        logic [1:0]        swap;
        logic [1:0]        typ;
        logic [WORD_W-1:0] res;
        logic [5:0]        k6;
        logic [4:0]        k5;
        logic [5:0]        lo;
        logic [4:0]        mid;
        logic [4:0]        top;
        logic [WORD_W-1:0] ka_sh;
        swap = {pd[8], pd[7]};
        typ  = {pd[12], pd[2]};
        res  = permute(w, PERM_SEL[swap]) ^ kb;

        case (typ)
            KEY_T0:  k6 = TYPE0_KEY;
            KEY_T1:  k6 = {pe[15], pe[8], pe[3], pd[1], pd[1], pd[0]};
            KEY_T2:  k6 = {pe[14], pe[13], pe[3], pe[7], pd[5], pe[5]};
            default: k6 = {pd[11], pe[2], pd[4], pe[6], pe[9], pe[0]};
        endcase
        lo  = res[5:0] + (k6 ^ ka[5:0]);
        res = {res[15:6], lo} ^ ka;

        case (typ)
            KEY_T0:  k5 = {res[4], res[5], w[5], res[2], w[9]};
            KEY_T1:  k5 = {pd[12], res[1], pd[14], pe[4], pd[2]};
            KEY_T2:  k5 = {pd[7], res[0], pd[15], pd[6], pe[6]};
            default: k5 = {pe[10], pd[1], pe[5], pd[9], pd[2]};
        endcase
        k5    = k5 ^ ka[4:0];
        mid   = res[10:6] + k5;
        top   = res[15:11] + k5;
        ka_sh = WORD_W'(ka << 6) | WORD_W'(ka << 11);
        res   = {top, mid, res[5:0]} ^ ka_sh;

        return permute(res, PERM_FINAL);
    endfunction

endpackage

`default_nettype wire

// ----- hdl/cwd_in_if.sv -----
// ----------------------------------------------------------------------------
// cwd_in_if
// input channel: encrypted write with offset and program counter
// ----------------------------------------------------------------------------
`default_nettype none

interface cwd_in_if;
    logic                       valid;
    logic                       ready;
    logic [cwd_pkg::OFF_W-1:0]  word_offset;
    logic [cwd_pkg::WORD_W-1:0] cipher_word;
    logic [cwd_pkg::PC_W-1:0]   program_counter;

    modport source (output valid, output word_offset, output cipher_word,
                    output program_counter, input ready);
    modport sink   (input valid, input word_offset, input cipher_word,
                    input program_counter, output ready);
endinterface

`default_nettype wire

// ----- hdl/cwd_out_if.sv -----
// ----------------------------------------------------------------------------
// cwd_out_if
// output channel: decrypted word
// ----------------------------------------------------------------------------
`default_nettype none

interface cwd_out_if;
    logic                       valid;
    logic                       ready;
    logic [cwd_pkg::WORD_W-1:0] plain_word;

    modport source (output valid, output plain_word, input ready);
    modport sink   (input valid, input plain_word, output ready);
endinterface

`default_nettype wire

// ----- hdl/cwd_pair.sv -----
// ----------------------------------------------------------------------------
// cwd_pair
// pair start tracking and chain detection
// ----------------------------------------------------------------------------
`default_nettype none

module cwd_pair (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_upd,
    input  wire logic [cwd_pkg::OFF_W-1:0]  i_off,
    input  wire logic [cwd_pkg::WORD_W-1:0] i_word,
    input  wire logic [cwd_pkg::PC_W-1:0]   i_pc,
    input  wire logic [cwd_pkg::WORD_W-1:0] i_plain,
    output cwd_pkg::t_pair_ctx              o_ctx
);
    import cwd_pkg::*;

    logic [PC_W-1:0]   r_pair_pc;
    logic [OFF_W-1:0]  r_pair_off;
    logic [WORD_W-1:0] r_prev_cipher;
    logic [WORD_W-1:0] r_prev_plain;
    logic              chain;

    // offset compare without wrap
    assign chain = (r_pair_pc == i_pc) &&
                   ({1'b0, i_off} == ({1'b0, r_pair_off} + (OFF_W + 1)'(1)));

    assign o_ctx = {chain,
                    chain ? r_prev_cipher : '0,
                    chain ? r_prev_plain : '0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_pc     <= '0;
            r_pair_off    <= '0;
            r_prev_cipher <= '0;
            r_prev_plain  <= '0;
        end else if (i_upd) begin
            if (chain) begin
                r_pair_pc <= '0;
            end else begin
                r_pair_pc     <= i_pc;
                r_pair_off    <= i_off;
                r_prev_cipher <= i_word;
                r_prev_plain  <= i_plain;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/cwd_unscr.sv -----
// ----------------------------------------------------------------------------
// cwd_unscr
// one-pass word descramble from keys and pair context
// ----------------------------------------------------------------------------
`default_nettype none

module cwd_unscr (
    input  wire logic [cwd_pkg::WORD_W-1:0] i_key_a,
    input  wire logic [cwd_pkg::WORD_W-1:0] i_key_b,
    input  wire cwd_pkg::t_pair_ctx         i_ctx,
    input  wire logic [cwd_pkg::WORD_W-1:0] i_word,
    output logic      [cwd_pkg::WORD_W-1:0] o_plain
);
    import cwd_pkg::*;

    assign o_plain = descramble(i_key_a, i_key_b, i_ctx.prev_cipher,
                                i_ctx.prev_plain, i_word);

endmodule

`default_nettype wire

// ----- hdl/chained_word_descrambler.sv -----
// ----------------------------------------------------------------------------
// chained_word_descrambler
// decrypts video memory writes, chaining on program counter and offset
// path: an input transfer loads the input register, then the result register
// throughput: one transfer per cycle unless the result side stalls; the pair
//   state and both pipeline registers update together so a chained word
//   follows its start directly
// reset: synchronous active low, clears valids, keys and pair state
// ----------------------------------------------------------------------------
`default_nettype none

module chained_word_descrambler (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    cwd_in_if.sink                             i_in,
    cwd_out_if.source                          o_out,
    input  wire logic                          i_cfg_we,
    input  wire logic [cwd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [cwd_pkg::WORD_W-1:0]    i_cfg_data
);
    import cwd_pkg::*;

    logic              cfg_key_a;
    logic [WORD_W-1:0] r_ka;
    logic [WORD_W-1:0] r_kb;

    logic              r_s1_vld;
    logic [OFF_W-1:0]  r_s1_off;
    logic [WORD_W-1:0] r_s1_word;
    logic [PC_W-1:0]   r_s1_pc;

    logic              r_out_vld;
    logic [WORD_W-1:0] r_out_plain;

    logic              s1_adv;
    logic              s1_fire;
    logic              in_fire;
    logic [WORD_W-1:0] n_plain;
    t_pair_ctx         ctx;

    assign s1_adv     = !r_out_vld || o_out.ready;
    assign s1_fire    = r_s1_vld && s1_adv;
    assign i_in.ready = !r_s1_vld || s1_adv;
    assign in_fire    = i_in.valid && i_in.ready;

    assign o_out.valid      = r_out_vld;
    assign o_out.plain_word = r_out_plain;

    assign cfg_key_a = (i_cfg_idx == CFG_KEY_A);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ka <= '0;
            r_kb <= '0;
        end else if (i_cfg_we) begin
            if (cfg_key_a) begin
                r_ka <= i_cfg_data;
            end else if (i_cfg_idx == CFG_KEY_B) begin
                r_kb <= i_cfg_data;
            end
        end
    end

    cwd_pair u_pair (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (s1_fire),
        .i_off   (r_s1_off),
        .i_word  (r_s1_word),
        .i_pc    (r_s1_pc),
        .i_plain (n_plain),
        .o_ctx   (ctx)
    );

    cwd_unscr u_unscr (
        .i_key_a (r_ka),
        .i_key_b (r_kb),
        .i_ctx   (ctx),
        .i_word  (r_s1_word),
        .o_plain (n_plain)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_off  <= i_in.word_offset;
            r_s1_word <= i_in.cipher_word;
            r_s1_pc   <= i_in.program_counter;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_plain <= n_plain;
        end
    end

`ifndef SYNTHESIS
    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_vld)
        else $error("result valid set after reset");

    a_fire_gives_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire |=> r_out_vld && r_out_plain == $past(n_plain))
        else $error("stage transfer lost its result");

    a_stall_holds_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && !s1_adv |=> r_s1_vld && $stable(r_s1_word) && $stable(r_s1_pc))
        else $error("stalled input register changed");

    a_no_accept_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && r_out_vld && !o_out.ready |-> !i_in.ready)
        else $error("transfer taken while both stages are full");
`endif

endmodule

`default_nettype wire

// ----- tb/cwd_checker.sv -----
// ----------------------------------------------------------------------------
// cwd_checker
// Watches the write and result channels of chained_word_descrambler. It keeps
// its own copy of the keys and the pair state and works out the plain word for
// every accepted write. Each accepted result is compared in order with the
// oldest of these words. It reports the number of words still outstanding and
// the number of failures to the testbench top.
// ----------------------------------------------------------------------------
module cwd_checker
    import cwd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    cwd_in_if                    i_in_mon,
    cwd_out_if                   i_out_mon,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [WORD_W-1:0]    i_cfg_data,
    output int                   o_pending,
    output int                   o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // source bit of result bit b sits in nibble b
    localparam logic [63:0] SEL_SRC [4] = '{
        64'h120e_cf48_d736_b5a9,
        64'hea4f_16cb_809d_7352,
        64'h2df1_c8e4_6095_a73b,
        64'h381d_e4f0_a27c_6b95
    };
    localparam logic [63:0] FINAL_SRC    = 64'h260b_ec7a_5483_91df;
    localparam logic [5:0]  FIXED_SUBKEY = 6'h3a;

    logic [WORD_W-1:0] key_a;
    logic [WORD_W-1:0] key_b;
    logic [PC_W-1:0]   pair_pc;
    logic [OFF_W-1:0]  pair_off;
    logic [WORD_W-1:0] last_cipher;
    logic [WORD_W-1:0] last_plain;
    logic [WORD_W-1:0] plain_q [$];
    int                fails = 0;

    function automatic logic [WORD_W-1:0] shuffle(input logic [WORD_W-1:0] v,
                                                  input logic [63:0] src);
        logic [WORD_W-1:0] r;
        for (int b = 0; b < WORD_W; b++) begin
            r[b] = v[src[4*b +: 4]];
        end
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] decrypt_word(input logic [WORD_W-1:0] ka,
                                                       input logic [WORD_W-1:0] kb,
                                                       input logic [WORD_W-1:0] pe,
                                                       input logic [WORD_W-1:0] pd,
                                                       input logic [WORD_W-1:0] w);
        logic [1:0]        sel;
        logic [1:0]        kind;
        logic [WORD_W-1:0] x;
        logic [5:0]        k6;
        logic [5:0]        low;
        logic [4:0]        k5;
        logic [4:0]        mid;
        logic [4:0]        high;
        sel  = {pd[8], pd[7]};
        kind = {pd[12], pd[2]};
        x    = shuffle(w, SEL_SRC[sel]) ^ kb;

        case (kind)
            KEY_T0:  k6 = FIXED_SUBKEY;
            KEY_T1:  k6 = {pe[15], pe[8], pe[3], pd[1], pd[1], pd[0]};
            KEY_T2:  k6 = {pe[14], pe[13], pe[3], pe[7], pd[5], pe[5]};
            default: k6 = {pd[11], pe[2], pd[4], pe[6], pe[9], pe[0]};
        endcase
        low = x[5:0] + (k6 ^ ka[5:0]);
        x   = {x[15:6], low} ^ ka;

        case (kind)
            KEY_T0:  k5 = {x[4], x[5], w[5], x[2], w[9]};
            KEY_T1:  k5 = {pd[12], x[1], pd[14], pe[4], pd[2]};
            KEY_T2:  k5 = {pd[7], x[0], pd[15], pd[6], pe[6]};
            default: k5 = {pe[10], pd[1], pe[5], pd[9], pd[2]};
        endcase
        k5   = k5 ^ ka[4:0];
        mid  = x[10:6] + k5;
        high = x[15:11] + k5;
        x    = {high, mid, x[5:0]} ^ ((ka << 6) | (ka << 11));

        return shuffle(x, FINAL_SRC);
    endfunction

    // chains to the pair start on same pc and next offset, no wrap at the top
    function automatic logic [WORD_W-1:0] next_plain(input logic [OFF_W-1:0] off,
                                                     input logic [WORD_W-1:0] w,
                                                     input logic [PC_W-1:0] pc);
        logic [WORD_W-1:0] p;
        if (pair_pc == pc && {1'b0, off} == {1'b0, pair_off} + 24'd1) begin
            pair_pc = '0;
            p = decrypt_word(key_a, key_b, last_cipher, last_plain, w);
        end else begin
            pair_pc     = pc;
            pair_off    = off;
            last_cipher = w;
            p = decrypt_word(key_a, key_b, '0, '0, w);
            last_plain  = p;
        end
        return p;
    endfunction

    always @(posedge i_clk) begin
        logic [WORD_W-1:0] want;
        logic [WORD_W-1:0] got;
        if (!i_rst_n) begin
            key_a       = '0;
            key_b       = '0;
            pair_pc     = '0;
            pair_off    = '0;
            last_cipher = '0;
            last_plain  = '0;
            plain_q.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_KEY_A: key_a = i_cfg_data;
                    CFG_KEY_B: key_b = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                got = i_out_mon.plain_word;
                if (plain_q.size() == 0) begin
                    $error("plain_word %h arrived with no transfer waiting for it", got);
                    fails++;
                end else begin
                    want = plain_q.pop_front();
                    if (got !== want) begin
                        $error("plain_word mismatch: expected %h, actual %h", want, got);
                        fails++;
                    end
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                plain_q.push_back(next_plain(i_in_mon.word_offset, i_in_mon.cipher_word,
                                             i_in_mon.program_counter));
            end
            o_pending <= plain_q.size();
        end
        o_fail_count <= fails;
    end

endmodule

// ----- tb/tb_chained_word_descrambler.sv -----
// ----------------------------------------------------------------------------
// tb_chained_word_descrambler
// Drives encrypted writes into chained_word_descrambler: a short directed set
// around pair chaining, offset wrap and program counter zero, then random
// bursts of chained pairs, broken pairs and lone writes under several key
// settings. Both channels idle at random, and one phase holds the result side
// off long enough to stall the input. The checker does the comparing.
// ----------------------------------------------------------------------------
module tb_chained_word_descrambler;
    import cwd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 4;
    localparam int STUCK_LIMIT  = 2000;
    localparam int PHASES       = 9;
    localparam int PHASE_WRITES = 150;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [WORD_W-1:0]    cfg_data;
    int                   pending;
    int                   fail_count;
    int                   stuck = 0;
    int                   writes_sent = 0;
    int                   hold_requests = 0;
    bit                   src_stalls = 1'b0;
    bit                   sink_stalls = 1'b0;

    cwd_in_if  in_ch ();
    cwd_out_if out_ch ();

    chained_word_descrambler DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    cwd_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always #1 clk = ~clk;

    always @(posedge clk) begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stuck <= 0;
        end else begin
            stuck <= stuck + 1;
        end
        if (stuck >= STUCK_LIMIT) begin
            $display("chained_word_descrambler test failed");
            $finish;
        end
    end

    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(10, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [OFF_W-1:0] pick_offset();
        if ($urandom_range(0, 15) == 0) begin
            return OFF_W'($urandom_range(23'h7ffffd, 23'h7fffff));
        end
        return OFF_W'($urandom);
    endfunction

    // result side
    initial begin
        int holds_done;
        holds_done = 0;
        forever begin
            if (holds_done < hold_requests) begin
                holds_done++;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap_len()) @(posedge clk);
            end else begin
                out_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    task automatic send_write(input logic [OFF_W-1:0] off, input logic [WORD_W-1:0] w,
                              input logic [PC_W-1:0] pc);
        if (src_stalls && $urandom_range(0, 2) == 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap_len()) @(posedge clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.word_offset     <= off;
        in_ch.cipher_word     <= w;
        in_ch.program_counter <= pc;
        do @(posedge clk); while (!in_ch.ready);
        writes_sent++;
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_keys(input logic [WORD_W-1:0] ka, input logic [WORD_W-1:0] kb);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_KEY_A;
        cfg_data <= ka;
        @(posedge clk);
        cfg_idx  <= CFG_KEY_B;
        cfg_data <= kb;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic random_burst();
        logic [OFF_W-1:0] off;
        logic [PC_W-1:0]  pc;
        int               shape;
        off   = pick_offset();
        pc    = PC_W'($urandom);
        shape = $urandom_range(0, 9);
        send_write(off, WORD_W'($urandom), pc);
        case (shape)
            0, 1, 2, 3, 4, 5: send_write(off + 1'b1, WORD_W'($urandom), pc);
            6: begin
                send_write(off + 1'b1, WORD_W'($urandom), pc);
                send_write(off + 1'b1, WORD_W'($urandom), '0);
            end
            7: send_write(off + 1'b1, WORD_W'($urandom),
                          pc ^ (PC_W'(1) << $urandom_range(0, PC_W - 1)));
            8: send_write($urandom_range(0, 1) ? off + 2'd2 : off, WORD_W'($urandom), pc);
            default: ;
        endcase
    endtask

    initial begin
        int target;
        rst_n                 <= 1'b0;
        in_ch.valid           <= 1'b0;
        in_ch.word_offset     <= '0;
        in_ch.cipher_word     <= '0;
        in_ch.program_counter <= '0;
        cfg_we                <= 1'b0;
        cfg_idx               <= CFG_KEY_A;
        cfg_data              <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_keys(16'h0000, 16'h0000);
        // pc zero chains against the cleared pair state
        send_write(23'h000001, 16'hffff, 24'h000000);
        send_write(23'h000001, 16'h0000, 24'h000000);
        // a pair started at the top offset never chains to the wrapped offset zero
        send_write(23'h7fffff, 16'hffff, 24'hffffff);
        send_write(23'h000000, 16'h0000, 24'hffffff);
        send_write(23'h7ffffe, 16'h0000, 24'hffffff);
        send_write(23'h7fffff, 16'hffff, 24'hffffff);
        send_write(23'h7fffff, 16'h1234, 24'h000000);
        // pc mismatch breaks the pair
        send_write(23'h000100, 16'h8001, 24'h123456);
        send_write(23'h000101, 16'h7ffe, 24'h123457);
        send_write(23'h000102, 16'h5a5a, 24'h123457);
        send_write(23'h000200, 16'ha5a5, 24'habcdef);
        send_write(23'h000200, 16'h3c3c, 24'habcdef);
        send_write(23'h555555, 16'h5555, 24'haaaaaa);
        send_write(23'h555556, 16'haaaa, 24'haaaaaa);
        send_write(23'h2aaaaa, 16'h0f0f, 24'h555555);
        send_write(23'h2aaaab, 16'hf0f0, 24'h555555);

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       load_keys(16'hffff, 16'hffff);
                1:       load_keys(16'hffff, 16'h0000);
                2:       load_keys(16'h0000, 16'hffff);
                3:       load_keys(16'h5555, 16'haaaa);
                default: load_keys(WORD_W'($urandom), WORD_W'($urandom));
            endcase
            src_stalls  = (phase % 3 != 0);
            sink_stalls = (phase % 3 != 0);
            if (phase == 4) begin
                src_stalls = 1'b0;
                hold_requests++;
            end
            target = writes_sent + PHASE_WRITES;
            while (writes_sent < target) begin
                random_burst();
            end
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("chained_word_descrambler test passed");
        end else begin
            $display("chained_word_descrambler test failed");
        end
        $finish;
    end

endmodule
